// ===== hw/rtl/murmur2_hash_with_range_reduce_macros.svh =====
// Assertion macros shared by the hash block RTL.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef MURMUR2_HASH_WITH_RANGE_REDUCE_MACROS_SVH
`define MURMUR2_HASH_WITH_RANGE_REDUCE_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define MM2RR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition implies the consequence in the next cycle.
`define MM2RR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mm2rr_pkg.sv =====
// ----------------------------------------------------------------------------
// mm2rr_pkg
// Types and constants shared by the hash block, its channels and its divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mm2rr_pkg;

  // Hash constants.
  localparam logic [31:0] MixMul      = 32'h5bd1e995;
  localparam int unsigned WordShift   = 24;
  localparam int unsigned FinalShiftA = 13;
  localparam int unsigned FinalShiftB = 15;

  // Field widths.
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned LengthW = 31;
  localparam int unsigned BoundW  = 31;

  // One input transfer.
  typedef struct packed {
    logic [WordW-1:0]   data_word;
    logic [CountW-1:0]  byte_count;
    logic [LengthW-1:0] total_length;
    logic               last_item;
    logic               reduce_enable;
    logic [BoundW-1:0]  range_bound;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [WordW-1:0] hash_result;
  } out_item_t;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Mask that keeps the valid low bytes of a short tail word.
  function automatic logic [WordW-1:0] tail_mask(input logic [CountW-1:0] count);
    logic [WordW-1:0] m;
    case (count)
      3'd3:    m = 32'h00FF_FFFF;
      3'd2:    m = 32'h0000_FFFF;
      default: m = 32'h0000_00FF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mm2rr_in_if.sv =====
// ----------------------------------------------------------------------------
// mm2rr_in_if
// Valid/ready channel that carries message words into the hash block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mm2rr_in_if ();
  logic                valid;
  logic                ready;
  mm2rr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mm2rr_out_if.sv =====
// ----------------------------------------------------------------------------
// mm2rr_out_if
// Valid/ready channel that carries finished hash values out of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mm2rr_out_if ();
  logic                 valid;
  logic                 ready;
  mm2rr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mm2rr_divider.sv =====
// ----------------------------------------------------------------------------
// mm2rr_divider
// Restoring bit-serial divider that returns the remainder of a 32-bit value
// by a 31-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mm2rr_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mm2rr_pkg::div_ctl_t              ctl,
  input  wire logic [mm2rr_pkg::WordW-1:0]      dividend,
  input  wire logic [mm2rr_pkg::BoundW-1:0]     divisor,
  output mm2rr_pkg::div_sts_t                   sts,
  output logic [mm2rr_pkg::WordW-1:0]           remainder
);

  `include "murmur2_hash_with_range_reduce_macros.svh"

  localparam int unsigned StepW = $clog2(mm2rr_pkg::WordW);

  logic                            busy;
  logic                            done;
  logic [StepW-1:0]                step;
  logic [mm2rr_pkg::WordW-1:0]     dvd;
  logic [mm2rr_pkg::BoundW-1:0]    dsr;
  logic [mm2rr_pkg::BoundW-1:0]    rem;
  logic [mm2rr_pkg::WordW-1:0]     trial;
  logic [mm2rr_pkg::WordW:0]       diff;
  logic [mm2rr_pkg::BoundW-1:0]    rem_next;

  // Shift in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    trial    = {rem, dvd[mm2rr_pkg::WordW-1]};
    diff     = {1'b0, trial} - {2'b00, dsr};
    rem_next = diff[mm2rr_pkg::WordW] ? trial[mm2rr_pkg::BoundW-1:0]
                                      : diff[mm2rr_pkg::BoundW-1:0];
  end

  // Control state clears on reset; the datapath registers do not need to.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= StepW'(mm2rr_pkg::WordW - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[mm2rr_pkg::WordW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign sts       = {busy, done};
  assign remainder = {1'b0, rem};

  `MM2RR_ASSERT_SAME(a_start_when_free, ctl.start, !busy, "divider started while busy")
  `MM2RR_ASSERT_SAME(a_done_in_range, done, rem < dsr, "remainder not below divisor")
  `MM2RR_ASSERT_NEXT(a_done_after_last_step, busy && step == '0 && !ctl.start,
                     done && !busy, "divider did not finish after its last step")

endmodule

`default_nettype wire

// ===== hw/rtl/murmur2_hash_with_range_reduce.sv =====
// ----------------------------------------------------------------------------
// murmur2_hash_with_range_reduce
// 32-bit MurmurHash2 over little-endian message words, with an optional
// reduction of the final hash modulo a bound.
// ----------------------------------------------------------------------------
//
//   channel | role   | payload
//   --------+--------+--------------------------------------------------------
//   msg     | sink   | data_word, byte_count, total_length, last_item,
//           |        | reduce_enable, range_bound
//   hash    | source | hash_result (one transfer per message)
//
// All multiplications go through one 32x32 multiplier by the mix constant,
// used once per cycle under the sequencer. A full word steps through K1, K2
// and MH, a tail word through TAIL, and an empty non-final item is taken in
// IDLE. The last item adds the final mix and output, plus the bit-serial
// divider when reduction applies with a bound of 2 or more. Input ready is
// high only while the sequencer is idle; a result waits in the output
// register until the sink takes it, and the next result waits behind it.
// Reset is synchronous and returns the block to idle with no message open.
//
`timescale 1ns / 1ps
`default_nettype none

module murmur2_hash_with_range_reduce (
  input wire logic   clk,
  input wire logic   rst,
  mm2rr_in_if.sink   msg,
  mm2rr_out_if.source hash
);

  `include "murmur2_hash_with_range_reduce_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_MH,
    ST_TAIL,
    ST_FIN1,
    ST_FIN2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUT
  } state_t;

  state_t                           state;
  logic                             in_message;
  logic [mm2rr_pkg::WordW-1:0]      h;
  logic [mm2rr_pkg::WordW-1:0]      k;
  logic [mm2rr_pkg::WordW-1:0]      w;
  logic [mm2rr_pkg::CountW-1:0]     cnt;
  logic                             last_r;
  logic                             reduce_r;
  logic [mm2rr_pkg::BoundW-1:0]     bound_r;
  logic                             out_valid;
  logic [mm2rr_pkg::WordW-1:0]      out_data;

  logic                             accept;
  logic [mm2rr_pkg::WordW-1:0]      h_start;
  logic [mm2rr_pkg::WordW-1:0]      mul_op;
  logic [mm2rr_pkg::WordW-1:0]      product;
  logic                             bound_small;
  logic                             out_free;

  mm2rr_pkg::div_ctl_t              div_ctl;
  mm2rr_pkg::div_sts_t              div_sts;
  logic [mm2rr_pkg::WordW-1:0]      div_rem;

  assign msg.ready = (state == ST_IDLE);
  assign accept    = msg.valid && msg.ready;
  assign h_start   = in_message ? h : {1'b0, msg.data.total_length};
  assign bound_small = (bound_r < mm2rr_pkg::BoundW'(2));
  assign out_free  = !out_valid || hash.ready;

  // Operand select for the shared multiplier; the other factor is constant.
  always_comb begin
    case (state)
      ST_K1:   mul_op = w;
      ST_K2:   mul_op = k ^ (k >> mm2rr_pkg::WordShift);
      ST_MH:   mul_op = h;
      ST_TAIL: mul_op = h ^ (w & mm2rr_pkg::tail_mask(cnt));
      ST_FIN1: mul_op = h ^ (h >> mm2rr_pkg::FinalShiftA);
      default: mul_op = h;
    endcase
  end

  assign product = mul_op * mm2rr_pkg::MixMul;

  // The divider is launched only for a reduction with a bound of 2 or more.
  assign div_ctl.start = (state == ST_DIV_GO);

  mm2rr_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (h),
    .divisor   (bound_r),
    .sts       (div_sts),
    .remainder (div_rem)
  );

  // Sequencer, working registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_message <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // The output register fills with a finished hash or empties on a transfer.
      if (state == ST_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (hash.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state) inside
        ST_IDLE: begin
          if (accept) begin
            h        <= h_start;
            w        <= msg.data.data_word;
            cnt      <= msg.data.byte_count;
            last_r   <= msg.data.last_item;
            reduce_r <= msg.data.reduce_enable;
            bound_r  <= msg.data.range_bound;
            if (msg.data.byte_count[2]) begin
              state <= ST_K1;
            end else if (msg.data.byte_count != '0) begin
              state <= ST_TAIL;
            end else if (msg.data.last_item) begin
              state <= ST_FIN1;
            end else begin
              in_message <= 1'b1;
            end
          end
        end
        ST_K1: begin
          k     <= product;
          state <= ST_K2;
        end
        ST_K2: begin
          k     <= product;
          state <= ST_MH;
        end
        ST_MH, ST_TAIL: begin
          h <= (state == ST_MH) ? (product ^ k) : product;
          if (last_r) begin
            state <= ST_FIN1;
          end else begin
            in_message <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_FIN1: begin
          h     <= product;
          state <= ST_FIN2;
        end
        ST_FIN2: begin
          if (reduce_r && bound_small) begin
            h     <= '0;
            state <= ST_PUT;
          end else begin
            h     <= h ^ (h >> mm2rr_pkg::FinalShiftB);
            state <= reduce_r ? ST_DIV_GO : ST_PUT;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_sts.done) begin
            h     <= div_rem;
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            out_data   <= h;
            in_message <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign hash.valid            = out_valid;
  assign hash.data.hash_result = out_data;

  `MM2RR_ASSERT_SAME(a_div_start_needed, div_ctl.start, reduce_r && !bound_small,
                     "divider started without a usable bound")
  `MM2RR_ASSERT_SAME(a_div_done_expected, div_sts.done, state == ST_DIV_WAIT,
                     "divider finished outside its wait state")
  `MM2RR_ASSERT_NEXT(a_result_from_put, !out_valid && state != ST_PUT, !out_valid,
                     "result appeared without passing the output state")
  `MM2RR_ASSERT_NEXT(a_open_after_middle, accept && !msg.data.last_item
                     && msg.data.byte_count == '0, in_message && state == ST_IDLE,
                     "empty middle item did not keep the message open")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming MurmurHash2 block with range reduce.
// Directed corner messages run first, then about two thousand random message
// words, most of them in well-formed messages with random content and the
// rest as malformed items. A local hash model predicts every result and a
// monitor compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [31:0] MIX_MULT      = 32'h5bd1e995;
  localparam int          WORD_ROT      = 24;
  localparam int          AVAL_SHIFT_A  = 13;
  localparam int          AVAL_SHIFT_B  = 15;
  localparam int          RANDOM_WORDS  = 2000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          STALL_LIMIT   = 5000;
  localparam int          MAX_REPORTS   = 10;

  logic clk;
  logic rst;

  mm2rr_in_if  msg_ch ();
  mm2rr_out_if hash_ch ();

  murmur2_hash_with_range_reduce dut (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg_ch),
    .hash (hash_ch)
  );

  // Words waiting to be sent and hashes waiting to come out.
  mm2rr_pkg::in_item_t word_q[$];
  logic [31:0]         expected_hashes[$];

  // Local copy of the running hash state.
  logic [31:0] model_acc;
  logic        model_open;

  int words_total;
  int words_sent;
  int hold_start_at;
  int hold_left;
  bit hold_done;
  int errors;
  int messages_done;
  int reduced_done;
  int results_seen;
  int stall_cycles;

  always #10 clk = ~clk;

  // ------------------------------------------------------------------------
  // Hash model
  // ------------------------------------------------------------------------

  // Full word: scramble the word and merge it into the running hash.
  function automatic logic [31:0] mix_full_word(input logic [31:0] h,
                                                input logic [31:0] w);
    logic [31:0] k;
    k = w * MIX_MULT;
    k = k ^ (k >> WORD_ROT);
    k = k * MIX_MULT;
    return (h * MIX_MULT) ^ k;
  endfunction

  // Short tail: xor in the valid low bytes, then multiply.
  function automatic logic [31:0] fold_short_tail(input logic [31:0] h,
                                                  input logic [31:0] w,
                                                  input logic [2:0]  cnt);
    logic [31:0] keep;
    case (cnt)
      3'd3:    keep = 32'h00FF_FFFF;
      3'd2:    keep = 32'h0000_FFFF;
      default: keep = 32'h0000_00FF;
    endcase
    return (h ^ (w & keep)) * MIX_MULT;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] v;
    v = h ^ (h >> AVAL_SHIFT_A);
    v = v * MIX_MULT;
    return v ^ (v >> AVAL_SHIFT_B);
  endfunction

  // Absorb one accepted word; a final word queues the expected hash.
  task automatic hash_absorb(input mm2rr_pkg::in_item_t it);
    logic [31:0] h;
    h = model_open ? model_acc : {1'b0, it.total_length};
    if (it.byte_count >= 3'd4) begin
      h = mix_full_word(h, it.data_word);
    end else if (it.byte_count != 3'd0) begin
      h = fold_short_tail(h, it.data_word, it.byte_count);
    end
    if (!it.last_item) begin
      model_acc  = h;
      model_open = 1'b1;
    end else begin
      h = avalanche(h);
      if (it.reduce_enable) begin
        h = (it.range_bound < 31'd2) ? 32'd0 : (h % {1'b0, it.range_bound});
        reduced_done++;
      end
      expected_hashes.push_back(h);
      messages_done++;
      model_acc  = '0;
      model_open = 1'b0;
    end
  endtask

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  function automatic void queue_word(input logic [31:0] w, input logic [2:0] cnt,
                                     input logic [30:0] len, input logic fin,
                                     input logic red, input logic [30:0] bound);
    mm2rr_pkg::in_item_t it;
    it.data_word     = w;
    it.byte_count    = cnt;
    it.total_length  = len;
    it.last_item     = fin;
    it.reduce_enable = red;
    it.range_bound   = bound;
    word_q.push_back(it);
  endfunction

  function automatic logic [30:0] pick_bound();
    case ($urandom_range(0, 6))
      0:       return 31'd0;
      1:       return 31'd1;
      2:       return 31'd2;
      3:       return 31'h7FFF_FFFF;
      4:       return 31'($urandom_range(3, 1000));
      default: return 31'($urandom);
    endcase
  endfunction

  // A well-formed message with random content and a mostly correct length.
  function automatic void queue_message();
    int          nfull;
    int          tail;
    logic [30:0] len;
    bit          fold_last;
    nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
    tail  = $urandom_range(0, 3);
    len   = 31'(nfull * 4 + tail);
    if ($urandom_range(0, 9) == 0) begin
      len = 31'($urandom);
    end
    // With no tail the last full word may itself close the message.
    fold_last = (tail == 0) && (nfull > 0) && $urandom_range(0, 1);
    for (int i = 0; i < nfull; i++) begin
      if (fold_last && i == nfull - 1) begin
        queue_word($urandom, 3'd4, (i == 0) ? len : 31'($urandom), 1'b1,
                   1'($urandom), pick_bound());
      end else begin
        queue_word($urandom, 3'd4, (i == 0) ? len : 31'($urandom), 1'b0,
                   1'($urandom), 31'($urandom));
      end
    end
    if (!fold_last) begin
      queue_word($urandom, 3'(tail), (nfull == 0) ? len : 31'($urandom), 1'b1,
                 1'($urandom), pick_bound());
    end
  endfunction

  // A malformed word: any byte count, any position in a message.
  function automatic void queue_noise();
    queue_word($urandom, 3'($urandom_range(0, 7)), 31'($urandom),
               ($urandom_range(0, 3) == 0), 1'($urandom), pick_bound());
  endfunction

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    msg_ch.valid    = 1'b0;
    msg_ch.data     = '0;
    hash_ch.ready   = 1'b0;
    model_acc       = '0;
    model_open      = 1'b0;
    errors          = 0;
    messages_done   = 0;
    reduced_done    = 0;
    results_seen    = 0;

    // Directed corners: empty messages, each tail size, counts above four,
    // short and empty words inside a message, small bounds, bad lengths.
    queue_word(32'h0000_0000, 3'd0, 31'd0, 1'b1, 1'b0, 31'd0);
    queue_word(32'hFFFF_FFFF, 3'd0, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFF);
    queue_word(32'hFFFF_FF61, 3'd1, 31'd1, 1'b1, 1'b0, 31'd0);
    queue_word(32'hA5A5_6261, 3'd2, 31'd2, 1'b1, 1'b1, 31'd2);
    queue_word(32'h8063_6261, 3'd3, 31'd3, 1'b1, 1'b1, 31'd1);
    queue_word(32'hFFFF_FFFF, 3'd4, 31'd8, 1'b0, 1'b0, 31'd0);
    queue_word(32'h0000_0000, 3'd4, 31'd0, 1'b1, 1'b1, 31'd0);
    queue_word(32'h1234_5678, 3'd5, 31'd12, 1'b0, 1'b0, 31'd0);
    queue_word(32'hDEAD_BEEF, 3'd6, 31'd0, 1'b0, 1'b0, 31'd0);
    queue_word(32'h0000_0000, 3'd7, 31'd0, 1'b0, 1'b0, 31'd0);
    queue_word(32'hFFFF_FFFF, 3'd0, 31'd0, 1'b1, 1'b1, 31'd3);
    queue_word(32'hFFFF_FFFF, 3'd0, 31'd5, 1'b0, 1'b0, 31'd0);
    queue_word(32'hFFFF_1234, 3'd2, 31'd0, 1'b0, 1'b1, 31'd0);
    queue_word(32'hCAFE_F00D, 3'd4, 31'd0, 1'b0, 1'b1, 31'd0);
    queue_word(32'hFFFF_FF7F, 3'd1, 31'd0, 1'b1, 1'b1, 31'h7FFF_FFFE);
    queue_word(32'h0102_0304, 3'd4, 31'd100, 1'b0, 1'b0, 31'd0);
    queue_word(32'hFF00_FF00, 3'd3, 31'd0, 1'b1, 1'b0, 31'h7FFF_FFFF);
    queue_word(32'h7FFF_FFFF, 3'd4, 31'd0, 1'b1, 1'b1, 31'h0001_0000);

    // Random part: mostly well-formed messages, some malformed words.
    while (word_q.size() < RANDOM_WORDS + 18) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_message();
      end else begin
        queue_noise();
      end
    end
    words_total   = word_q.size();
    hold_start_at = words_total - 250;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every hash to come back.
    while (word_q.size() != 0 || msg_ch.valid) @(posedge clk);
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d messages, %0d hashes checked, %0d of them reduced.",
             words_sent, messages_done, results_seen, reduced_done);
    $display("Both sides stalled at random, and the output was held off for %0d cycles.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors found", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // Driver: offers queued words, idling at the rate of the current phase.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    int idle_pct;
    if (words_sent < words_total / 3) begin
      idle_pct = 26;
    end else if (words_sent < (2 * words_total) / 3) begin
      idle_pct = 58;
    end else begin
      idle_pct = 0;
    end
    if (rst) begin
      msg_ch.valid <= 1'b0;
      words_sent   <= 0;
    end else begin
      if (msg_ch.valid && msg_ch.ready) begin
        words_sent <= words_sent + 1;
      end
      if (!msg_ch.valid || msg_ch.ready) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          msg_ch.valid <= 1'b1;
          msg_ch.data  <= word_q.pop_front();
        end else begin
          msg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long output hold-off late in the run while words keep coming.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= hold_start_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: checks each hash transfer, then absorbs any accepted word.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    int                   idle_pct;
    mm2rr_pkg::out_item_t got;
    if (words_sent < words_total / 3) begin
      idle_pct = 58;
    end else if (words_sent < (2 * words_total) / 3) begin
      idle_pct = 26;
    end else begin
      idle_pct = 0;
    end
    if (rst) begin
      hash_ch.ready <= 1'b0;
    end else begin
      hash_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);

      // Results come out in order, each after the last word of its message.
      if (hash_ch.valid && hash_ch.ready) begin
        got = hash_ch.data;
        results_seen++;
        if (expected_hashes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected hash transfer, hash_result=%h", $realtime,
                     got.hash_result);
          end
        end else if (got.hash_result !== expected_hashes[0]) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: hash_result mismatch, expected %h, got %h", $realtime,
                     expected_hashes[0], got.hash_result);
          end
          void'(expected_hashes.pop_front());
        end else begin
          void'(expected_hashes.pop_front());
        end
      end

      if (msg_ch.valid && msg_ch.ready) begin
        hash_absorb(msg_ch.data);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (hash_ch.valid && hash_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d hashes still due", $realtime,
               STALL_LIMIT, expected_hashes.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mm2rr_pkg.sv
hw/rtl/mm2rr_in_if.sv
hw/rtl/mm2rr_out_if.sv
hw/rtl/mm2rr_divider.sv
hw/rtl/murmur2_hash_with_range_reduce.sv
bench/tb_top.sv
